// ----- src/serial_poll_master_assert.svh -----
// Assertion shorthands for the checker of the serial poll master.
// Both expect signals named clk and arst_n in the scope of use.
`ifndef SERIAL_POLL_MASTER_ASSERT_SVH
`define SERIAL_POLL_MASTER_ASSERT_SVH

// same-cycle implication
`define SPM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/spm_pkg.sv -----
`default_nettype none

package spm_pkg;

	localparam int HEAD_DEPTH = 5;
	localparam int HEAD_IDX_W = $clog2(HEAD_DEPTH);
	localparam int REQ_LEN = 6;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CMD_PING   = 2'd0,
		CMD_STATUS = 2'd1,
		CMD_INPUTS = 2'd2
	} cmd_t;

	localparam logic [2:0] RES_OK       = 3'd0;
	localparam logic [2:0] RES_TIMEOUT  = 3'd1;
	localparam logic [2:0] RES_CHECKSUM = 3'd2;
	localparam logic [2:0] RES_EMPTY    = 3'd3;
	localparam logic [2:0] RES_INVALID  = 3'd4;

	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_RESULT = 1'b1;

	localparam logic [7:0] CFG_OWN_ADDRESS   = 8'd0;
	localparam logic [7:0] CFG_REPLY_TIMEOUT = 8'd1;

	localparam logic [7:0] REQ_LEN_BYTE = 8'h03;
	localparam logic [7:0] REQ_PAD_BYTE = 8'h00;
	localparam logic [7:0] TAG_PING     = 8'h05;
	localparam logic [7:0] TAG_STATUS   = 8'h03;
	localparam logic [7:0] TAG_INPUTS   = 8'h02;

	typedef logic [HEAD_DEPTH-1:0][7:0] head_t;

	// transaction state seen by the reply evaluator
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] target;
		logic [3:0] count;
		logic [7:0] xor_acc;
		logic       any_nz;
		head_t      head;
	} txn_t;

	typedef struct packed {
		logic       done;
		logic [2:0] code;
		logic [7:0] value_a;
		logic [7:0] value_b;
		logic [3:0] count;
		logic [7:0] xor_acc;
		logic       any_nz;
	} eval_t;

	function automatic logic [3:0] reply_length(input logic [1:0] cmd);
		case (cmd)
			CMD_PING:   return 4'd8;
			CMD_STATUS: return 4'd6;
			default:    return 4'd5;
		endcase
	endfunction

	function automatic logic [7:0] reply_tag(input logic [1:0] cmd);
		case (cmd)
			CMD_PING:   return TAG_PING;
			CMD_STATUS: return TAG_STATUS;
			default:    return TAG_INPUTS;
		endcase
	endfunction

	function automatic logic [7:0] req_byte(input logic [2:0] idx, input logic [7:0] tgt,
			input logic [7:0] own, input logic [1:0] cmd);
		case (idx)
			3'd0:    return tgt;
			3'd1:    return own;
			3'd2:    return REQ_LEN_BYTE;
			3'd3:    return REQ_PAD_BYTE;
			3'd4:    return {6'd0, cmd};
			default: return tgt ^ own ^ REQ_LEN_BYTE ^ REQ_PAD_BYTE ^ {6'd0, cmd};
		endcase
	endfunction

endpackage

`default_nettype wire

// ----- src/serial_poll_master.sv -----
// Path: an item is taken into the input register at the accepting edge, then into the
// result register once that is free and no request bytes are pending.
// Throughput: one item per cycle while out_ready and the sequencer allow; a start holds
// the input while its 6 request bytes pass through the single result register.
// Reset (arst_n low): idle, no result pending, own address 0, reply timeout 500 ticks.
// Reply header store is not reset; only bytes of the current reply are read.
`default_nettype none

module serial_poll_master import spm_pkg::*; #(
	parameter int TIMER_BITS = 16
) (
	input  var logic        clk,
	input  var logic        arst_n,
	input  var logic        cfg_valid,
	output var logic        cfg_ready,
	input  var logic [7:0]  cfg_index,
	input  var logic [15:0] cfg_data,
	input  var logic        in_valid,
	output var logic        in_ready,
	input  var logic [1:0]  op,
	input  var logic [1:0]  command,
	input  var logic [7:0]  target_address,
	input  var logic [7:0]  rx_byte,
	output var logic        out_valid,
	input  var logic        out_ready,
	output var logic        kind,
	output var logic [7:0]  tx_byte,
	output var logic        last,
	output var logic [2:0]  result_code,
	output var logic [7:0]  value_a,
	output var logic [7:0]  value_b
);

	localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam logic [TIMER_BITS-1:0] TICK_MAX = {TIMER_BITS{1'b1}};

	// configuration
	logic [7:0]  own_address_q;
	logic [15:0] reply_timeout_q;

	// input register
	logic       valid_s1;
	logic [1:0] op_s1;
	logic [1:0] command_s1;
	logic [7:0] target_s1;
	logic [7:0] rx_s1;

	// transaction state
	logic                  busy_q;
	logic [1:0]            cmd_q;
	logic [7:0]            target_q;
	logic [3:0]            count_q;
	logic [7:0]            xor_q;
	logic                  any_q;
	head_t                 head_q;
	logic [TIMER_BITS-1:0] tick_q;

	// request byte sequencer
	logic       seq_busy_q;
	logic [2:0] seq_idx_q;

	// result register
	logic       out_valid_q;
	logic       kind_q;
	logic [7:0] tx_q;
	logic       last_q;
	logic [2:0] code_q;
	logic [7:0] va_q;
	logic [7:0] vb_q;

	txn_t                  txn;
	eval_t                 ev;
	logic                  out_free;
	logic                  fire_s1;
	logic [TIMER_BITS-1:0] tick_next;
	logic                  timed_out;
	logic                  start_ok;
	logic                  emit;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign fire_s1   = valid_s1 && out_free && !seq_busy_q;
	assign in_ready  = !valid_s1 || fire_s1;

	assign txn.cmd     = cmd_q;
	assign txn.target  = target_q;
	assign txn.count   = count_q;
	assign txn.xor_acc = xor_q;
	assign txn.any_nz  = any_q;
	assign txn.head    = head_q;

	spm_eval u_eval (
		.txn         (txn),
		.own_address (own_address_q),
		.rx_byte     (rx_s1),
		.res         (ev)
	);

	assign tick_next = (tick_q == TICK_MAX) ? tick_q : tick_q + TIMER_BITS'(1);
	assign timed_out = (CMP_W'(tick_next) >= CMP_W'(reply_timeout_q));
	assign start_ok  = !busy_q && (command_s1 <= CMD_INPUTS);

	// result register loads a new item this cycle
	assign emit = (seq_busy_q && out_free) || (fire_s1 && (
		(op_s1 == OP_START && start_ok) ||
		(op_s1 == OP_BYTE && busy_q && ev.done) ||
		(op_s1 == OP_TICK && busy_q && timed_out)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q   <= 8'd0;
			reply_timeout_q <= 16'd500;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OWN_ADDRESS:   own_address_q   <= cfg_data[7:0];
				CFG_REPLY_TIMEOUT: reply_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1      <= op;
			command_s1 <= command;
			target_s1  <= target_address;
			rx_s1      <= rx_byte;
		end
	end

	// reply header store, written only while collecting
	always_ff @(posedge clk) begin
		if (fire_s1 && op_s1 == OP_BYTE && busy_q && count_q < 4'(HEAD_DEPTH)) begin
			head_q[count_q[HEAD_IDX_W-1:0]] <= rx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cmd_q       <= 2'd0;
			target_q    <= 8'd0;
			count_q     <= 4'd0;
			xor_q       <= 8'd0;
			any_q       <= 1'b0;
			tick_q      <= '0;
			seq_busy_q  <= 1'b0;
			seq_idx_q   <= 3'd0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_TX;
			tx_q        <= 8'd0;
			last_q      <= 1'b0;
			code_q      <= RES_OK;
			va_q        <= 8'd0;
			vb_q        <= 8'd0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (seq_busy_q && out_free) begin
				kind_q      <= KIND_TX;
				tx_q        <= req_byte(seq_idx_q, target_q, own_address_q, cmd_q);
				last_q      <= (seq_idx_q == 3'(REQ_LEN - 1));
				code_q      <= RES_OK;
				va_q        <= 8'd0;
				vb_q        <= 8'd0;
				seq_idx_q   <= seq_idx_q + 3'd1;
				if (seq_idx_q == 3'(REQ_LEN - 1)) seq_busy_q <= 1'b0;
			end else if (fire_s1) begin
				case (op_s1)
					OP_START: begin
						if (start_ok) begin
							busy_q      <= 1'b1;
							cmd_q       <= command_s1;
							target_q    <= target_s1;
							count_q     <= 4'd0;
							xor_q       <= 8'd0;
							any_q       <= 1'b0;
							tick_q      <= '0;
							kind_q      <= KIND_TX;
							tx_q        <= target_s1;
							last_q      <= 1'b0;
							code_q      <= RES_OK;
							va_q        <= 8'd0;
							vb_q        <= 8'd0;
							seq_busy_q  <= 1'b1;
							seq_idx_q   <= 3'd1;
						end
					end
					OP_BYTE: begin
						if (busy_q) begin
							if (ev.done) begin
								busy_q      <= 1'b0;
								count_q     <= 4'd0;
								xor_q       <= 8'd0;
								any_q       <= 1'b0;
								tick_q      <= '0;
								kind_q      <= KIND_RESULT;
								tx_q        <= 8'd0;
								last_q      <= 1'b1;
								code_q      <= ev.code;
								va_q        <= ev.value_a;
								vb_q        <= ev.value_b;
							end else begin
								count_q <= ev.count;
								xor_q   <= ev.xor_acc;
								any_q   <= ev.any_nz;
							end
						end
					end
					OP_TICK: begin
						if (busy_q) begin
							if (timed_out) begin
								busy_q      <= 1'b0;
								count_q     <= 4'd0;
								xor_q       <= 8'd0;
								any_q       <= 1'b0;
								tick_q      <= '0;
								kind_q      <= KIND_RESULT;
								tx_q        <= 8'd0;
								last_q      <= 1'b1;
								code_q      <= RES_TIMEOUT;
								va_q        <= 8'd0;
								vb_q        <= 8'd0;
							end else begin
								tick_q <= tick_next;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign tx_byte     = tx_q;
	assign last        = last_q;
	assign result_code = code_q;
	assign value_a     = va_q;
	assign value_b     = vb_q;

endmodule

`default_nettype wire

// ----- src/spm_eval.sv -----
`default_nettype none

// Folds one reply byte into the transaction and grades the reply once complete.
module spm_eval import spm_pkg::*; (
	input  var txn_t       txn,
	input  var logic [7:0] own_address,
	input  var logic [7:0] rx_byte,
	output eval_t          res
);

	logic [7:0] xor_next;
	logic       any_next;
	logic [3:0] count_next;

	assign xor_next   = txn.xor_acc ^ rx_byte;
	assign any_next   = txn.any_nz | (rx_byte != 8'd0);
	assign count_next = txn.count + 4'd1;

	always_comb begin
		res         = '0;
		res.count   = count_next;
		res.xor_acc = xor_next;
		res.any_nz  = any_next;
		res.done    = (count_next >= reply_length(txn.cmd));
		// header bytes always arrive before the final byte
		if (xor_next != 8'd0) begin
			res.code = RES_CHECKSUM;
		end else if (!any_next) begin
			res.code = RES_EMPTY;
		end else if (txn.head[0] != own_address || txn.head[1] != txn.target ||
				txn.head[2] != reply_tag(txn.cmd)) begin
			res.code = RES_INVALID;
		end else begin
			res.code = RES_OK;
			if (txn.cmd == CMD_STATUS) begin
				res.value_a = txn.head[3];
				res.value_b = txn.head[4];
			end else if (txn.cmd == CMD_INPUTS) begin
				res.value_a = txn.head[3];
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/spm_checker.sv -----
`default_nettype none

`include "serial_poll_master_assert.svh"

module spm_checker import spm_pkg::*; (
	input var logic       clk,
	input var logic       arst_n,
	input var logic       out_valid,
	input var logic       out_ready,
	input var logic       kind,
	input var logic [7:0] tx_byte,
	input var logic       last,
	input var logic [2:0] result_code,
	input var logic [7:0] value_a,
	input var logic [7:0] value_b
);

	`SPM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped while stalled")
	`SPM_ASSERT_IMP(a_result_last, out_valid && kind == KIND_RESULT, last && tx_byte == 8'd0, "result item without last or with tx byte")
	`SPM_ASSERT_IMP(a_tx_clean, out_valid && kind == KIND_TX, result_code == RES_OK && value_a == 8'd0 && value_b == 8'd0, "transmit item carries result fields")
	`SPM_ASSERT_IMP(a_code_range, out_valid, result_code == RES_OK || result_code == RES_TIMEOUT || result_code == RES_CHECKSUM || result_code == RES_EMPTY || result_code == RES_INVALID, "result code out of range")
	`SPM_ASSERT_NXT(a_after_last_tx, out_valid && out_ready && kind == KIND_TX && !last, out_valid && kind == KIND_TX, "request bytes not contiguous")

endmodule

bind serial_poll_master spm_checker u_spm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.kind        (kind),
	.tx_byte     (tx_byte),
	.last        (last),
	.result_code (result_code),
	.value_a     (value_a),
	.value_b     (value_b)
);

`default_nettype wire
